>>> hw/rtl/cigar_match_to_eq_x_rewriter_defines.svh
// assertion macros shared by the rewriter modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef CIGAR_MATCH_TO_EQ_X_REWRITER_DEFINES_SVH
`define CIGAR_MATCH_TO_EQ_X_REWRITER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CMEQX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CMEQX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cmeqx_pkg.sv
// shared op codes, constants and types of the cigar =/X rewriter
// no dependencies
package cmeqx_pkg;

  // cigar op codes
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  // ascii 'N' in the reference
  localparam logic [7:0] CHAR_N = 8'h4E;

  // result kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_MASK = 1'b1;

  // mask byte geometry
  localparam int unsigned MASK_BITS = 8;
  localparam logic [2:0]  MASK_TOP  = 3'd7;

  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // which results one column produced; emitted chg, end, then mask
  typedef struct packed {
    logic last;     // final result of the record
    logic msk_vld;  // mask byte
    logic end_vld;  // run closed by run or record end
    logic chg_vld;  // run closed by op change
  } cmeqx_flags_t;

endpackage

>>> hw/rtl/cmeqx_queue.sv
// small register queue of result bundles between front and back
// depends on cmeqx_pkg for the depth
module cmeqx_queue
  import cmeqx_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  `include "cigar_match_to_eq_x_rewriter_defines.svh"

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == DepthC);
  assign empty_o = (cnt_q == '0);

  `CMEQX_ASSERT_IMP(a_no_overflow, push_i, !full_o || pop_i, "queue written while full")
  `CMEQX_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "queue read while empty")
  `CMEQX_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= DepthC, "queue fill count out of range")

endmodule

>>> hw/rtl/cmeqx_front.sv
// front end: classifies each column, tracks the open run and the n-mask,
// and hands a bundle of up to three results to the queue; uses cmeqx_pkg
module cmeqx_front
  import cmeqx_pkg::*;
#(
  parameter int unsigned RUN_COUNT_BITS = 28
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [3:0]                op_i,
  input  logic [7:0]                query_base_i,
  input  logic [7:0]                ref_base_i,
  input  logic                      run_end_i,
  input  logic                      record_end_i,
  output logic                      push_o,
  output cmeqx_flags_t              flags_o,
  output logic [3:0]                chg_op_o,
  output logic [RUN_COUNT_BITS-1:0] chg_cnt_o,
  output logic [3:0]                end_op_o,
  output logic [RUN_COUNT_BITS-1:0] end_cnt_o,
  output logic [7:0]                mask_byte_o
);

  `include "cigar_match_to_eq_x_rewriter_defines.svh"

  localparam logic [RUN_COUNT_BITS-1:0] CountMax = '1;

  logic [3:0]                cur_op_q, cur_op_d;
  logic [RUN_COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [MASK_BITS-1:0]      acc_q, acc_d;
  logic [2:0]                pos_q, pos_d;
  logic                      pend_q, pend_d;

  logic [3:0]                eop;
  logic                      cons_ref;
  logic                      chg;
  logic                      close_end;
  logic [RUN_COUNT_BITS-1:0] base_cnt;
  logic [RUN_COUNT_BITS-1:0] new_cnt;
  logic [MASK_BITS-1:0]      acc_next;
  logic                      byte_full;
  logic                      msk_vld;

  // op mapping and reference use
  always_comb begin
    if (op_i == OP_M) begin
      eop = (query_base_i == ref_base_i) ? OP_EQ : OP_X;
    end else begin
      eop = op_i;
    end
    cons_ref = (op_i == OP_M) || (op_i == OP_D) || (op_i == OP_N) ||
               (op_i == OP_EQ) || (op_i == OP_X);
  end

  // run tracking: close on op change, extend/start, run/record end closes
  always_comb begin
    chg       = (cnt_q != '0) && (cur_op_q != eop);
    base_cnt  = chg ? '0 : cnt_q;
    if (base_cnt == '0) begin
      new_cnt = {{(RUN_COUNT_BITS-1){1'b0}}, 1'b1};
    end else if (base_cnt != CountMax) begin
      new_cnt = base_cnt + 1'b1;
    end else begin
      new_cnt = base_cnt;
    end
    close_end = run_end_i || record_end_i;
    if (close_end) begin
      cur_op_d = '0;
      cnt_d    = '0;
    end else begin
      cur_op_d = eop;
      cnt_d    = new_cnt;
    end
  end

  // n-mask: one bit per reference column, full byte or record end emits
  always_comb begin
    acc_next = acc_q;
    if (cons_ref && (ref_base_i == CHAR_N)) begin
      acc_next = acc_q | (MASK_BITS'(1) << pos_q);
    end
    byte_full = cons_ref && (pos_q == MASK_TOP);
    msk_vld   = byte_full || (record_end_i && (cons_ref || pend_q));
    acc_d     = acc_q;
    pos_d     = pos_q;
    pend_d    = pend_q;
    if (byte_full || record_end_i) begin
      acc_d  = '0;
      pos_d  = '0;
      pend_d = 1'b0;
    end else if (cons_ref) begin
      acc_d  = acc_next;
      pos_d  = pos_q + 1'b1;
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_op_q <= '0;
      cnt_q    <= '0;
      acc_q    <= '0;
      pos_q    <= '0;
      pend_q   <= 1'b0;
    end else if (accept_i) begin
      cur_op_q <= cur_op_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      pos_q    <= pos_d;
      pend_q   <= pend_d;
    end
  end

  // result bundle
  always_comb begin
    flags_o.chg_vld = chg;
    flags_o.end_vld = close_end;
    flags_o.msk_vld = msk_vld;
    flags_o.last    = record_end_i;
    chg_op_o        = cur_op_q;
    chg_cnt_o       = cnt_q;
    end_op_o        = eop;
    end_cnt_o       = new_cnt;
    mask_byte_o     = acc_next;
    push_o          = accept_i && (chg || close_end || msk_vld);
  end

  `CMEQX_ASSERT_NXT(a_rec_clears, accept_i && record_end_i,
                    (cnt_q == '0) && (pos_q == '0) && !pend_q && (acc_q == '0),
                    "record end left state behind")
  `CMEQX_ASSERT_NXT(a_run_stays_open, accept_i && !record_end_i && !run_end_i,
                    cnt_q != '0, "open run lost without run end")
  `CMEQX_ASSERT_IMP(a_pend_pos, 1'b1, (pos_q == '0) || pend_q,
                    "mask bits counted without pending flag")

endmodule

>>> hw/rtl/cmeqx_back.sv
// back end: walks queue head results one per cycle, unless the output
// stalls, into the output register; uses cmeqx_pkg for flags and kinds
module cmeqx_back
  import cmeqx_pkg::*;
#(
  parameter int unsigned RUN_COUNT_BITS = 28
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  cmeqx_flags_t              flags_i,
  input  logic [3:0]                chg_op_i,
  input  logic [RUN_COUNT_BITS-1:0] chg_cnt_i,
  input  logic [3:0]                end_op_i,
  input  logic [RUN_COUNT_BITS-1:0] end_cnt_i,
  input  logic [7:0]                mask_byte_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      kind_o,
  output logic [3:0]                out_op_o,
  output logic [RUN_COUNT_BITS-1:0] run_count_o,
  output logic [7:0]                mask_byte_o,
  output logic                      last_o
);

  `include "cigar_match_to_eq_x_rewriter_defines.svh"

  // bit order {mask, end run, change run}
  logic [2:0] done_q, done_d;
  logic [2:0] rem;
  logic [2:0] sel;
  logic [2:0] after;
  logic       fin;
  logic       take;

  logic                      valid_q, valid_d;
  logic                      kind_q, kind_d;
  logic [3:0]                op_q, op_d;
  logic [RUN_COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [7:0]                mb_q, mb_d;
  logic                      last_q, last_d;

  // pick the next unsent result of the head bundle
  always_comb begin
    rem = {flags_i.msk_vld, flags_i.end_vld, flags_i.chg_vld} & ~done_q;
    if (rem[0]) begin
      sel = 3'b001;
    end else if (rem[1]) begin
      sel = 3'b010;
    end else begin
      sel = 3'b100;
    end
    after = rem & ~sel;
    fin   = (after == '0);
    take  = !empty_i && (!valid_q || out_ready_i);
    pop_o = take && fin;
    if (take) begin
      done_d = fin ? '0 : (done_q | sel);
    end else begin
      done_d = done_q;
    end
  end

  // output register load
  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    mb_d    = mb_q;
    last_d  = last_q;
    if (take) begin
      valid_d = 1'b1;
      last_d  = flags_i.last && fin;
      if (sel[0]) begin
        kind_d = KIND_RUN;
        op_d   = chg_op_i;
        cnt_d  = chg_cnt_i;
        mb_d   = '0;
      end else if (sel[1]) begin
        kind_d = KIND_RUN;
        op_d   = end_op_i;
        cnt_d  = end_cnt_i;
        mb_d   = '0;
      end else begin
        kind_d = KIND_MASK;
        op_d   = '0;
        cnt_d  = '0;
        mb_d   = mask_byte_i;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      done_q  <= done_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    op_q   <= op_d;
    cnt_q  <= cnt_d;
    mb_q   <= mb_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign out_op_o    = op_q;
  assign run_count_o = cnt_q;
  assign mask_byte_o = mb_q;
  assign last_o      = last_q;

  `CMEQX_ASSERT_IMP(a_head_has_work, !empty_i, rem != '0,
                    "queue head with no result left to send")
  `CMEQX_ASSERT_IMP(a_mask_fields, valid_q && (kind_q == KIND_MASK),
                    (op_q == '0) && (cnt_q == '0), "mask byte carries run fields")
  `CMEQX_ASSERT_IMP(a_run_nonzero, valid_q && (kind_q == KIND_RUN),
                    (cnt_q != '0) && (mb_q == '0), "run result with zero length")

endmodule

>>> hw/rtl/cigar_match_to_eq_x_rewriter.sv
// Cigar M-to-=/X rewriter with reference N-mask. Takes one alignment column
// per input transaction and gives run results (op, length) and N-mask bytes.
// A column is accepted in every cycle while the four-entry result queue has
// room; each column queues a bundle of zero to three results, and the back end
// sends one result per cycle while the output is ready, so the sustained rate
// is one column per cycle as long as columns average at most one result each
// (an op change together with a run end and a full mask byte gives three results).
// Results pass through the queue and the output register. No reset sweep is needed.
// depends on cmeqx_pkg, cmeqx_front, cmeqx_queue and cmeqx_back
module cigar_match_to_eq_x_rewriter
  import cmeqx_pkg::*;
#(
  parameter int unsigned RUN_COUNT_BITS = 28
) (
  input  logic clk_i,
  input  logic rst_ni,
  // input columns
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // op[3:0], query_base[11:4], ref_base[19:12]
  input  logic        s_axis_tuser_i,   // run_end
  input  logic        s_axis_tlast_i,   // record_end
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [((RUN_COUNT_BITS+12+7)/8)*8-1:0] m_axis_tdata_o, // out_op, run_count, mask_byte
  output logic        m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o    // last
);

  localparam int unsigned OutW    = ((RUN_COUNT_BITS + 12 + 7) / 8) * 8;
  localparam int unsigned BundleW = $bits(cmeqx_flags_t) + 2 * (4 + RUN_COUNT_BITS) + 8;

  logic                      accept;
  logic                      push;
  logic                      full;
  logic                      pop;
  logic                      empty;
  cmeqx_flags_t              f_flags;
  logic [3:0]                f_chg_op;
  logic [RUN_COUNT_BITS-1:0] f_chg_cnt;
  logic [3:0]                f_end_op;
  logic [RUN_COUNT_BITS-1:0] f_end_cnt;
  logic [7:0]                f_mask;
  logic [BundleW-1:0]        wdata;
  logic [BundleW-1:0]        rdata;
  cmeqx_flags_t              b_flags;
  logic [3:0]                b_chg_op;
  logic [RUN_COUNT_BITS-1:0] b_chg_cnt;
  logic [3:0]                b_end_op;
  logic [RUN_COUNT_BITS-1:0] b_end_cnt;
  logic [7:0]                b_mask;
  logic [3:0]                out_op;
  logic [RUN_COUNT_BITS-1:0] run_count;
  logic [7:0]                mask_byte;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  cmeqx_front #(
    .RUN_COUNT_BITS(RUN_COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (s_axis_tdata_i[3:0]),
    .query_base_i (s_axis_tdata_i[11:4]),
    .ref_base_i   (s_axis_tdata_i[19:12]),
    .run_end_i    (s_axis_tuser_i),
    .record_end_i (s_axis_tlast_i),
    .push_o       (push),
    .flags_o      (f_flags),
    .chg_op_o     (f_chg_op),
    .chg_cnt_o    (f_chg_cnt),
    .end_op_o     (f_end_op),
    .end_cnt_o    (f_end_cnt),
    .mask_byte_o  (f_mask)
  );

  // pack the bundle for the queue
  assign wdata = {f_flags, f_mask, f_end_cnt, f_end_op, f_chg_cnt, f_chg_op};

  cmeqx_queue #(
    .WIDTH(BundleW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rdata),
    .empty_o (empty)
  );

  assign {b_flags, b_mask, b_end_cnt, b_end_op, b_chg_cnt, b_chg_op} = rdata;

  cmeqx_back #(
    .RUN_COUNT_BITS(RUN_COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .flags_i     (b_flags),
    .chg_op_i    (b_chg_op),
    .chg_cnt_i   (b_chg_cnt),
    .end_op_i    (b_end_op),
    .end_cnt_i   (b_end_cnt),
    .mask_byte_i (b_mask),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .kind_o      (m_axis_tuser_o),
    .out_op_o    (out_op),
    .run_count_o (run_count),
    .mask_byte_o (mask_byte),
    .last_o      (m_axis_tlast_o)
  );

  // output payload, zero filled to whole bytes
  assign m_axis_tdata_o = OutW'({mask_byte, run_count, out_op});

endmodule
